@@ sv/assert_macros.svh @@
// Assertion macros shared by the cipher RTL.
// Uses the clock and reset names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Consequence must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/hce_pkg.sv @@
// Types, constants and the permutation table for the Hill cipher block.
// No dependencies; imported by hce_alu and hill_cipher_encrypt.
package hce_pkg;

   localparam int MAX_DIM     = 4;
   localparam int DIM_W       = 3;
   localparam int LETTER_W    = 5;
   localparam int KEY_ROW_W   = MAX_DIM * LETTER_W;
   localparam int CSR_INDEX_W = 3;
   localparam int ACC_W       = 26;
   localparam int PROD_W      = 20;
   localparam int PROD_X_W    = 15;
   localparam int SHIFT_W     = 5;
   localparam int PERM_W      = 5;
   localparam int NUM_PERMS   = 24;
   localparam int ALPHA       = 26;
   localparam int ALPHA_HALF  = 13;
   // reduction start shifts: det+bias < 26*2^21, column sums < 26*2^7
   localparam int DET_SHIFT   = 20;
   localparam int COL_SHIFT   = 6;

   localparam logic [ACC_W-1:0]    ALPHA_ACC  = ACC_W'(ALPHA);
   // multiple of 26 that keeps any determinant sum non-negative
   localparam logic [ACC_W-1:0]    DET_BIAS   = ALPHA_ACC << DET_SHIFT;
   localparam logic [7:0]          CHAR_A     = 8'h61;
   localparam logic [7:0]          CHAR_Z     = 8'h7a;
   localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

   typedef enum logic {
      KIND_CHAR  = 1'b0,
      KIND_FLUSH = 1'b1
   } hce_kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_SINGULAR   = 2'd1,
      ST_NO_INVERSE = 2'd2
   } hce_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_DIM   = 3'd0,
      CSR_KEY_ROW_0 = 3'd1,
      CSR_KEY_ROW_1 = 3'd2,
      CSR_KEY_ROW_2 = 3'd3,
      CSR_KEY_ROW_3 = 3'd4
   } hce_csr_type;

   typedef enum logic [2:0] {
      ALU_NOP     = 3'd0,
      ALU_BIAS    = 3'd1,
      ALU_CLEAR   = 3'd2,
      ALU_LOAD    = 3'd3,
      ALU_MUL     = 3'd4,
      ALU_MUL_ACC = 3'd5,
      ALU_MAC     = 3'd6,
      ALU_REDUCE  = 3'd7
   } hce_alu_op_type;

   typedef struct packed {
      hce_alu_op_type      op;
      logic                negate;
      logic [LETTER_W-1:0] ext;
      logic [LETTER_W-1:0] factor;
      logic [SHIFT_W-1:0]  shift;
   } hce_alu_ctl_type;

   typedef struct packed {
      hce_kind_type kind;
      logic [7:0]   ch;
   } hce_req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] cipher_letter;
      hce_status_type      status;
      logic                last_of_block;
   } hce_rsp_type;

   // Permutations of four columns in lexicographic order.
   // Bit 8 is odd parity, bits [2r+1:2r] give the column for row r.
   function automatic logic [8:0] perm_entry(input logic [PERM_W-1:0] idx);
      logic [8:0] e;
      case (idx)
         5'd0:    e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
         5'd1:    e = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
         5'd2:    e = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
         5'd3:    e = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
         5'd4:    e = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
         5'd5:    e = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
         5'd6:    e = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
         5'd7:    e = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
         5'd8:    e = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
         5'd9:    e = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
         5'd10:   e = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
         5'd11:   e = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
         5'd12:   e = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
         5'd13:   e = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
         5'd14:   e = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
         5'd15:   e = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
         5'd16:   e = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
         5'd17:   e = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
         5'd18:   e = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
         5'd19:   e = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
         5'd20:   e = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
         5'd21:   e = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
         5'd22:   e = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
         5'd23:   e = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

@@ sv/hce_alu.sv @@
// Shared arithmetic unit: one 15x5 multiplier, accumulator add/subtract,
// and a compare-subtract step for mod 26 reduction. Depends on hce_pkg.
module hce_alu
   import hce_pkg::*;
(
   input  logic            clock,
   input  hce_alu_ctl_type ctl,
   output logic [ACC_W-1:0] acc
);

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [PROD_X_W-1:0] mul_x;
   logic [PROD_W-1:0]   mul_res;
   logic [ACC_W-1:0]    mul_ext;
   logic [ACC_W-1:0]    divisor;

   always_comb begin
      mul_x   = (ctl.op == ALU_MAC) ? PROD_X_W'(ctl.ext) : prod_ff[PROD_X_W-1:0];
      mul_res = PROD_W'(mul_x) * PROD_W'(ctl.factor);
      mul_ext = ACC_W'(mul_res);
      divisor = ALPHA_ACC << ctl.shift;
   end

   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      case (ctl.op)
         ALU_BIAS:    acc_in  = DET_BIAS;
         ALU_CLEAR:   acc_in  = '0;
         ALU_LOAD:    prod_in = PROD_W'(ctl.factor);
         ALU_MUL:     prod_in = mul_res;
         ALU_MUL_ACC: acc_in  = ctl.negate ? acc_ff - mul_ext : acc_ff + mul_ext;
         ALU_MAC:     acc_in  = acc_ff + mul_ext;
         ALU_REDUCE: begin
            if (acc_ff >= divisor) begin
               acc_in = acc_ff - divisor;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

@@ sv/hill_cipher_encrypt.sv @@
// Hill cipher encryption, top level: key registers, letter buffer, sequencer
// and output register. Depends on hce_pkg, hce_alu and assert_macros.svh.
//
//   channel   direction   handshake            beat
//   req       in          req_valid/req_stall  hce_req_type {kind, ch}
//   rsp       out         rsp_valid/rsp_stall  hce_rsp_type {letter, status, last}
//   csr       in          csr_valid/csr_ready  csr_index, csr_wdata
//
// A byte that does not complete a block is only stored. A completed block holds
// req_stall high through a bias step, 96 determinant steps (24 permutations x 4
// rows on the one multiplier), 21 reduction steps and the checks, then for
// each cipher letter a column sum, its reduction and a beat, or a status beat.
// Reset is synchronous: key returns to the 2x2 identity, buffer count to zero.
// A stalled rsp beat holds the sequencer; csr writes are taken in any cycle.
`include "assert_macros.svh"

module hill_cipher_encrypt
   import hce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hce_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hce_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEY_ROW_W-1:0]   csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DET   = 8'b0000_0010,
      S_DZERO = 8'b0000_0100,
      S_DMOD  = 8'b0000_1000,
      S_CHECK = 8'b0001_0000,
      S_COL   = 8'b0010_0000,
      S_CMOD  = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } hce_state_type;

   localparam logic [1:0]        ROW_LAST  = 2'(MAX_DIM - 1);
   localparam logic [PERM_W-1:0] PERM_LAST = PERM_W'(NUM_PERMS - 1);

   hce_state_type        state_ff, state_in;
   logic [DIM_W-1:0]     key_dim_ff;
   logic [KEY_ROW_W-1:0] key_row_ff [MAX_DIM];
   logic [LETTER_W-1:0]  buf_ff [MAX_DIM];
   logic [1:0]           fill_ff;
   logic [PERM_W-1:0]    perm_ff, perm_in;
   logic [1:0]           row_ff, row_in;
   logic [1:0]           col_ff, col_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic                 det_zero_ff, det_zero_in;
   hce_status_type       status_ff, status_in;
   logic                 rsp_valid_ff;
   hce_rsp_type          rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]     dim;
   logic [1:0]           dim_last;
   logic                 req_fire;
   logic                 is_letter;
   logic [DIM_W-1:0]     fill_inc;
   logic                 start_block;
   logic [8:0]           perm_e;
   logic [1:0]           csel;
   logic [KEY_ROW_W-1:0] key_row_sel;
   logic [LETTER_W-1:0]  key_cells [MAX_DIM];
   logic [LETTER_W-1:0]  key_entry;
   logic [LETTER_W-1:0]  det_factor;
   logic                 rsp_load;
   logic                 last_emit;
   hce_alu_ctl_type      alu_ctl;
   logic [ACC_W-1:0]     alu_acc;

   hce_alu u_alu (
      .clock (clock),
      .ctl   (alu_ctl),
      .acc   (alu_acc)
   );

   // key dimension in use: zero acts as one, above MAX_DIM clamps
   always_comb begin
      if (key_dim_ff == '0) begin
         dim = DIM_W'(1);
      end else if (key_dim_ff > DIM_W'(MAX_DIM)) begin
         dim = DIM_W'(MAX_DIM);
      end else begin
         dim = key_dim_ff;
      end
      dim_last = 2'(dim - DIM_W'(1));
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign is_letter   = (req_data.kind == KIND_CHAR) &&
                        (req_data.ch >= CHAR_A) && (req_data.ch <= CHAR_Z);
   assign fill_inc    = DIM_W'(fill_ff) + DIM_W'(1);
   assign start_block = req_fire &&
                        ((is_letter && fill_inc >= dim) ||
                         (req_data.kind == KIND_FLUSH && fill_ff != '0));

   // one key entry read per cycle: row from row_ff, column by phase
   always_comb begin
      perm_e      = perm_entry(perm_ff);
      csel        = (state_ff == S_DET) ? perm_e[{row_ff, 1'b0} +: 2] : col_ff;
      key_row_sel = key_row_ff[row_ff];
      for (int c = 0; c < MAX_DIM; c++) begin
         key_cells[c] = key_row_sel[c*LETTER_W +: LETTER_W];
      end
      key_entry = key_cells[csel];
      // outside the active d x d corner the matrix reads as identity
      if (DIM_W'(row_ff) < dim && DIM_W'(csel) < dim) begin
         det_factor = key_entry;
      end else if (row_ff == csel) begin
         det_factor = LETTER_W'(1);
      end else begin
         det_factor = '0;
      end
   end

   assign last_emit = (status_ff != ST_OK) || (col_ff == dim_last);

   always_comb begin
      state_in    = state_ff;
      perm_in     = perm_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      shift_in    = shift_ff;
      det_zero_in = det_zero_ff;
      status_in   = status_ff;
      rsp_load    = 1'b0;
      alu_ctl.op     = ALU_NOP;
      alu_ctl.negate = perm_e[8];
      alu_ctl.ext    = buf_ff[row_ff];
      alu_ctl.factor = key_entry;
      alu_ctl.shift  = shift_ff;

      rsp_data_in.cipher_letter = (status_ff == ST_OK) ? alu_acc[LETTER_W-1:0] : '0;
      rsp_data_in.status        = status_ff;
      rsp_data_in.last_of_block = last_emit;

      case (state_ff)
         S_IDLE: begin
            if (start_block) begin
               alu_ctl.op = ALU_BIAS;
               perm_in    = '0;
               row_in     = '0;
               state_in   = S_DET;
            end
         end
         S_DET: begin
            alu_ctl.factor = det_factor;
            if (row_ff == '0) begin
               alu_ctl.op = ALU_LOAD;
            end else if (row_ff == ROW_LAST) begin
               alu_ctl.op = ALU_MUL_ACC;
            end else begin
               alu_ctl.op = ALU_MUL;
            end
            row_in = row_ff + 2'd1;
            if (row_ff == ROW_LAST) begin
               perm_in = perm_ff + PERM_W'(1);
               if (perm_ff == PERM_LAST) begin
                  state_in = S_DZERO;
               end
            end
         end
         S_DZERO: begin
            det_zero_in = (alu_acc == DET_BIAS);
            shift_in    = SHIFT_W'(DET_SHIFT);
            state_in    = S_DMOD;
         end
         S_DMOD: begin
            alu_ctl.op = ALU_REDUCE;
            shift_in   = shift_ff - SHIFT_W'(1);
            if (shift_ff == '0) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (det_zero_ff) begin
               status_in = ST_SINGULAR;
               state_in  = S_EMIT;
            end else if (!alu_acc[0] || alu_acc[LETTER_W-1:0] == LETTER_W'(ALPHA_HALF)) begin
               status_in = ST_NO_INVERSE;
               state_in  = S_EMIT;
            end else begin
               status_in  = ST_OK;
               alu_ctl.op = ALU_CLEAR;
               row_in     = '0;
               col_in     = '0;
               state_in   = S_COL;
            end
         end
         S_COL: begin
            alu_ctl.op = ALU_MAC;
            row_in     = row_ff + 2'd1;
            if (row_ff == dim_last) begin
               shift_in = SHIFT_W'(COL_SHIFT);
               state_in = S_CMOD;
            end
         end
         S_CMOD: begin
            alu_ctl.op = ALU_REDUCE;
            shift_in   = shift_ff - SHIFT_W'(1);
            if (shift_ff == '0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               if (last_emit) begin
                  state_in = S_IDLE;
               end else begin
                  alu_ctl.op = ALU_CLEAR;
                  col_in     = col_ff + 2'd1;
                  row_in     = '0;
                  state_in   = S_COL;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_block) begin
            fill_ff <= '0;
         end else if (req_fire && is_letter) begin
            fill_ff <= fill_inc[1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_dim_ff <= DIM_W'(2);
         for (int r = 0; r < MAX_DIM; r++) begin
            key_row_ff[r] <= KEY_ROW_W'(1) << (r * LETTER_W);
         end
      end else if (csr_valid && csr_ready) begin
         case (hce_csr_type'(csr_index))
            CSR_KEY_DIM:   key_dim_ff    <= csr_wdata[DIM_W-1:0];
            CSR_KEY_ROW_0: key_row_ff[0] <= csr_wdata;
            CSR_KEY_ROW_1: key_row_ff[1] <= csr_wdata;
            CSR_KEY_ROW_2: key_row_ff[2] <= csr_wdata;
            CSR_KEY_ROW_3: key_row_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // payload and sequencer counters
   always_ff @(posedge clock) begin
      perm_ff     <= perm_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      shift_ff    <= shift_in;
      det_zero_ff <= det_zero_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (req_fire && is_letter) begin
         buf_ff[fill_ff] <= LETTER_W'(req_data.ch - CHAR_A);
      end else if (req_fire && req_data.kind == KIND_FLUSH) begin
         // pad the unfilled slots of the block
         for (int i = 0; i < MAX_DIM; i++) begin
            if (DIM_W'(i) >= DIM_W'(fill_ff) && DIM_W'(i) < dim) begin
               buf_ff[i] <= PAD_LETTER;
            end
         end
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_HOLDS(a_status_beat, (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.last_of_block && rsp_data.cipher_letter == '0), "status beat not last or letter nonzero")
   `ASSERT_HOLDS(a_letter_range, rsp_valid |-> (rsp_data.cipher_letter < LETTER_W'(ALPHA)), "cipher letter out of range")
   `ASSERT_HOLDS(a_reduced, (state_ff == S_CHECK || state_ff == S_EMIT) |-> (alu_acc < ALPHA_ACC), "accumulator not reduced mod 26")
   `ASSERT_NEXT(a_last_idle, state_ff == S_EMIT && rsp_load && last_emit, state_ff == S_IDLE && rsp_valid && rsp_data.last_of_block, "last beat did not end the block")

endmodule
